FILE: rtl/core/rfpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfpe_pkg
// Types and constants shared by the remote frame pulse encoder modules.
// ----------------------------------------------------------------------------
package rfpe_pkg;

   localparam int LEN_W      = 16;
   localparam int ID_W       = 26;
   localparam int FRAME_W    = 36;
   localparam int BIT_IDX_W  = 6;
   localparam int LEVEL_W    = 5;
   localparam int DIM_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 26;

   localparam logic [BIT_IDX_W-1:0] ID_BITS          = 6'd26;
   localparam logic [BIT_IDX_W-1:0] PLAIN_FRAME_BITS = 6'd32;
   localparam logic [BIT_IDX_W-1:0] DIM_FRAME_BITS   = 6'd36;
   localparam logic [BIT_IDX_W-1:0] DOUBLE_SHORT_BIT = 6'd27;

   localparam logic [LEVEL_W-1:0] DIM_LEVEL_MIN = 5'd1;
   localparam logic [LEVEL_W-1:0] DIM_LEVEL_MAX = 5'd16;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SEND = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CLIENT_ID  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_LEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_END_LOW    = 3'd4;

   localparam logic [ID_W-1:0]  RST_CLIENT_ID = 26'd0;
   localparam logic [LEN_W-1:0] RST_UNIT_LEN  = 16'd250;
   localparam logic [LEN_W-1:0] RST_LONG_LOW  = 16'd1250;
   localparam logic [LEN_W-1:0] RST_START_LOW = 16'd2500;
   localparam logic [LEN_W-1:0] RST_END_LOW   = 16'd10000;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_START  = 3'd1,
      PH_FIRST  = 3'd2,
      PH_SECOND = 3'd3,
      PH_END    = 3'd4
   } phase_type;

   typedef struct packed {
      logic               opcode;
      logic [1:0]         group_sel;
      logic [1:0]         device_sel;
      logic               turn_on;
      logic               dim_cmd;
      logic [LEVEL_W-1:0] dim_level;
   } item_type;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic rejected;
   } result_type;

   typedef struct packed {
      logic [ID_W-1:0]  client_id;
      logic [LEN_W-1:0] unit_length;
      logic [LEN_W-1:0] long_low_length;
      logic [LEN_W-1:0] start_low_length;
      logic [LEN_W-1:0] end_low_length;
   } cfg_type;

endpackage
`default_nettype wire

FILE: rtl/core/rfpe_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfpe_csr
// Configuration registers: client id and the pulse and low lengths.
// ----------------------------------------------------------------------------
module rfpe_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wen,
   input  wire logic [rfpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rfpe_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output rfpe_pkg::cfg_type                     cfg
);
   import rfpe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_CLIENT_ID: cfg_in.client_id        = csr_wdata[ID_W-1:0];
            CSR_UNIT_LEN:  cfg_in.unit_length      = csr_wdata[LEN_W-1:0];
            CSR_LONG_LOW:  cfg_in.long_low_length  = csr_wdata[LEN_W-1:0];
            CSR_START_LOW: cfg_in.start_low_length = csr_wdata[LEN_W-1:0];
            CSR_END_LOW:   cfg_in.end_low_length   = csr_wdata[LEN_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.client_id        <= RST_CLIENT_ID;
         cfg_ff.unit_length      <= RST_UNIT_LEN;
         cfg_ff.long_low_length  <= RST_LONG_LOW;
         cfg_ff.start_low_length <= RST_START_LOW;
         cfg_ff.end_low_length   <= RST_END_LOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: rtl/core/rfpe_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfpe_in_stage
// Input register: captures one request transaction per cycle while it is empty or advancing.
// ----------------------------------------------------------------------------
module rfpe_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire rfpe_pkg::item_type    req_item,
   input  wire logic                  advance,
   output logic                       item_valid,
   output rfpe_pkg::item_type         item
);
   import rfpe_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

FILE: rtl/core/rfpe_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfpe_sequencer
// Frame builder and pulse sequencer: one command or tick per fire.
// ----------------------------------------------------------------------------
module rfpe_sequencer #(
   parameter int FRAME_REPEATS = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire rfpe_pkg::item_type item,
   input  wire rfpe_pkg::cfg_type  cfg,
   output rfpe_pkg::result_type  result
);
   import rfpe_pkg::*;

   localparam int RPT_W = $clog2(FRAME_REPEATS + 1);
   localparam logic [RPT_W-1:0] RPT_LAST = RPT_W'(FRAME_REPEATS - 1);

   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic                 dim_ff, dim_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   phase_type            phase_ff, phase_in;
   logic                 pulse_ff, pulse_in;
   logic [LEN_W-1:0]     tick_ff, tick_in;
   logic [RPT_W-1:0]     repeat_ff, repeat_in;
   logic                 active_ff, active_in;

   logic                 cur_bit;
   logic                 short_low;
   logic [LEN_W-1:0]     low_len;
   logic [LEN_W-1:0]     len_sel;
   logic [LEN_W-1:0]     len_eff;
   logic [LEN_W-1:0]     tick_inc;
   logic                 part_done;
   logic [BIT_IDX_W-1:0] bit_inc;
   logic [BIT_IDX_W-1:0] nbits;
   logic [DIM_W-1:0]     dim_val;
   logic [LEVEL_W-1:0]   level_m1;
   logic                 level_ok;

   // low period length of the current part
   assign cur_bit   = frame_ff[bit_ff];
   assign short_low = (phase_ff == PH_FIRST) == cur_bit;

   always_comb begin
      case (phase_ff)
         PH_START: low_len = cfg.start_low_length;
         PH_END:   low_len = cfg.end_low_length;
         default: begin
            if ((dim_ff && (bit_ff == DOUBLE_SHORT_BIT)) || short_low) begin
               low_len = cfg.unit_length;
            end else begin
               low_len = cfg.long_low_length;
            end
         end
      endcase
   end

   assign len_sel   = pulse_ff ? cfg.unit_length : low_len;
   assign len_eff   = (len_sel == '0) ? LEN_W'(1) : len_sel;
   assign tick_inc  = tick_ff + LEN_W'(1);
   assign part_done = (tick_inc >= len_eff) || (tick_inc == '0);
   assign bit_inc   = bit_ff + BIT_IDX_W'(1);
   assign nbits     = dim_ff ? DIM_FRAME_BITS : PLAIN_FRAME_BITS;
   assign level_m1  = item.dim_level - DIM_LEVEL_MIN;
   assign dim_val   = level_m1[DIM_W-1:0];
   assign level_ok  = (item.dim_level >= DIM_LEVEL_MIN) && (item.dim_level <= DIM_LEVEL_MAX);

   // next state
   always_comb begin
      frame_in  = frame_ff;
      dim_in    = dim_ff;
      bit_in    = bit_ff;
      phase_in  = phase_ff;
      pulse_in  = pulse_ff;
      tick_in   = tick_ff;
      repeat_in = repeat_ff;
      active_in = active_ff;
      if (fire) begin
         if (item.opcode == OP_SEND) begin
            if (!active_ff) begin
               for (int i = 0; i < ID_W; i++) begin
                  frame_in[ID_W - 1 - i] = cfg.client_id[i];
               end
               frame_in[26] = 1'b1;
               if (!item.dim_cmd) begin
                  frame_in[27] = !item.turn_on;
               end
               frame_in[28] = item.group_sel[1];
               frame_in[29] = item.group_sel[0];
               frame_in[30] = item.device_sel[1];
               frame_in[31] = item.device_sel[0];
               if (item.dim_cmd && level_ok) begin
                  for (int i = 0; i < DIM_W; i++) begin
                     frame_in[FRAME_W - 1 - i] = dim_val[i];
                  end
               end
               dim_in    = item.dim_cmd;
               active_in = 1'b1;
               phase_in  = PH_START;
               pulse_in  = 1'b1;
               tick_in   = '0;
               bit_in    = '0;
               repeat_in = '0;
            end
         end else if (active_ff) begin
            tick_in = tick_inc;
            if (part_done) begin
               tick_in = '0;
               if (pulse_ff) begin
                  pulse_in = 1'b0;
               end else begin
                  pulse_in = 1'b1;
                  case (phase_ff)
                     PH_START: begin
                        bit_in   = '0;
                        phase_in = PH_FIRST;
                     end
                     PH_FIRST: phase_in = PH_SECOND;
                     PH_SECOND: begin
                        bit_in   = bit_inc;
                        phase_in = (bit_inc >= nbits) ? PH_END : PH_FIRST;
                     end
                     default: begin
                        if (repeat_ff == RPT_LAST) begin
                           phase_in  = PH_IDLE;
                           active_in = 1'b0;
                           pulse_in  = 1'b0;
                           repeat_in = '0;
                           bit_in    = '0;
                        end else begin
                           repeat_in = repeat_ff + RPT_W'(1);
                           phase_in  = PH_START;
                        end
                     end
                  endcase
               end
            end
         end
      end
   end

   // result
   always_comb begin
      result.pin_level = 1'b0;
      result.busy_res  = 1'b0;
      result.rejected  = 1'b0;
      if (item.opcode == OP_SEND) begin
         result.busy_res = 1'b1;
         if (active_ff) begin
            result.pin_level = pulse_ff;
            result.rejected  = 1'b1;
         end
      end else if (active_ff) begin
         result.pin_level = pulse_ff;
         result.busy_res  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff  <= '0;
         dim_ff    <= 1'b0;
         bit_ff    <= '0;
         phase_ff  <= PH_IDLE;
         pulse_ff  <= 1'b0;
         tick_ff   <= '0;
         repeat_ff <= '0;
         active_ff <= 1'b0;
      end else begin
         frame_ff  <= frame_in;
         dim_ff    <= dim_in;
         bit_ff    <= bit_in;
         phase_ff  <= phase_in;
         pulse_ff  <= pulse_in;
         tick_ff   <= tick_in;
         repeat_ff <= repeat_in;
         active_ff <= active_in;
      end
   end

`ifndef ASSERT_OFF
   a_active_phase: assert property (@(posedge clock) disable iff (reset)
      active_ff == (phase_ff != PH_IDLE))
      else $error("active flag and phase disagree");

   a_pulse_active: assert property (@(posedge clock) disable iff (reset)
      pulse_ff |-> active_ff)
      else $error("line high while idle");

   a_repeat_range: assert property (@(posedge clock) disable iff (reset)
      repeat_ff <= RPT_LAST)
      else $error("repeat count out of range");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (fire && item.opcode == OP_SEND && active_ff) |=> ($stable(frame_ff) && active_ff))
      else $error("dropped command changed the frame");

   a_send_starts: assert property (@(posedge clock) disable iff (reset)
      (fire && item.opcode == OP_SEND && !active_ff)
         |=> (phase_ff == PH_START && pulse_ff && tick_ff == '0))
      else $error("accepted command did not start a frame");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/rf_remote_frame_pulse_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rf_remote_frame_pulse_encoder_top
// OOK pulse encoder for a self-learning 433 MHz remote control.
// ----------------------------------------------------------------------------
// One request transaction is either a time tick or a send command; every
// request yields exactly one response transaction with the data line level
// for that tick, the busy flag and the rejected flag. While the response side
// keeps up, a request is taken in every cycle: it is held in the input
// register, sequencer state updates as it moves into the result register,
// and its response is offered from there. A stalled response holds the
// input register, and with both registers full the request side stalls.
// A transmission is four frames of a start bit, 32 or 36 data bits of two
// physical bits each and an end bit, advanced by one tick per request.
// Configuration writes take effect on the next clock edge; write them only
// while no transaction is in flight.
// ----------------------------------------------------------------------------
module rf_remote_frame_pulse_encoder_top #(
   parameter int FRAME_REPEATS = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request: tdata = group_sel[1:0], device_sel[3:2], turn_on[4],
   //          dim_cmd[5], dim_level[10:6], zero fill [15:11]
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [15:0]                      req_tdata,
   // request: tuser = opcode[0]
   input  wire logic                             req_tuser,
   // response: tdata = pin_level[0], busy_res[1], rejected[2], zero fill [7:3]
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [7:0]                            rsp_tdata,
   input  wire logic                             csr_wen,
   input  wire logic [rfpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rfpe_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rfpe_pkg::*;

   cfg_type    cfg;
   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   logic       fire;
   result_type result;

   result_type out_ff;
   logic       out_valid_ff;
   logic       out_valid_in;

   assign req_item.opcode     = req_tuser;
   assign req_item.group_sel  = req_tdata[1:0];
   assign req_item.device_sel = req_tdata[3:2];
   assign req_item.turn_on    = req_tdata[4];
   assign req_item.dim_cmd    = req_tdata[5];
   assign req_item.dim_level  = req_tdata[10:6];

   rfpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rfpe_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   rfpe_sequencer #(
      .FRAME_REPEATS (FRAME_REPEATS)
   ) u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   assign advance = !out_valid_ff || rsp_tready;
   assign fire    = item_valid && advance;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.rejected, out_ff.busy_res, out_ff.pin_level};

endmodule
`default_nettype wire
